// ===== rtl/core/ale_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int OP_W     = 4;
  localparam int POS_W    = 11;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 10;
  localparam int CURSOR_W = 10;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 4'd0,
    OP_INSERT_AT   = 4'd1,
    OP_REMOVE_AT   = 4'd2,
    OP_REMOVE_LAST = 4'd3,
    OP_GET         = 4'd4,
    OP_UPDATE      = 4'd5,
    OP_SEARCH      = 4'd6,
    OP_CLEAR       = 4'd7,
    OP_CUR_START   = 4'd8,
    OP_CUR_END     = 4'd9,
    OP_CUR_NEXT    = 4'd10,
    OP_CUR_BACK    = 4'd11,
    OP_READ        = 4'd12,
    OP_WRITE       = 4'd13
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ale_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ale_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ale_pkg::OP_W-1:0]      opcode;
  logic [ale_pkg::POS_W-1:0]     position;
  ale_pkg::word_t                word_in;

  modport source (output valid, output opcode, output position, output word_in, input ready);
  modport sink (input valid, input opcode, input position, input word_in, output ready);
endinterface

interface ale_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ale_pkg::STATUS_W-1:0]  status;
  ale_pkg::word_t                word_out;
  logic [ale_pkg::FOUND_W-1:0]   found_at;
  logic [ale_pkg::CNT_W-1:0]     count_now;
  logic [ale_pkg::CURSOR_W-1:0]  cursor_now;

  modport source (output valid, output status, output word_out, output found_at,
                  output count_now, output cursor_now, input ready);
  modport sink (input valid, input status, input word_out, input found_at,
                input count_now, input cursor_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ale_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/array_list_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed 32-bit words held in a single-port-read,
// single-port-write synchronous store of 1024 entries, with a length count
// and a cursor. One command is taken at a time and each returns exactly one
// response item carrying status, data, search index, length and cursor.
// The store has no reset and needs no clearing pass: only words read from
// entries below the length are ever used. Get and read at cursor make one
// store read; insert at p below the count moves the words from p up by one,
// starting at the end, remove at p moves the words above p down by one, and
// search walks up from index 0 to the first match. Shifts and the search
// walk the store one word per cycle, paced by its one read and one write
// port, so the longest commands are an insert at 0 into 1023 words and a
// search of a full store with no match. A new command is taken while the
// previous response still waits on the output register; a finished command
// then holds until that register frees up.

module array_list_engine_unit (
  input wire logic  clk,
  input wire logic  rst,
  ale_cmd_if.sink   cmd,
  ale_rsp_if.source rsp
);

  localparam int AW = ale_pkg::ADDR_W;
  localparam int CW = ale_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SHIFT_R = 7'b0000010,
    S_PUT     = 7'b0000100,
    S_SHIFT_L = 7'b0001000,
    S_SEARCH  = 7'b0010000,
    S_WAIT_RD = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // list state
  logic [CW-1:0] cnt;
  logic [AW-1:0] cur;

  // per-command working registers
  logic [AW-1:0]              idx;
  logic [ale_pkg::POS_W-1:0]  pos_r;
  ale_pkg::word_t             word_r;
  ale_pkg::status_t           res_status;
  ale_pkg::status_t           res_status_next;
  ale_pkg::word_t             res_data;
  logic [ale_pkg::FOUND_W-1:0] res_found;

  // response register
  logic                          out_valid;
  logic [ale_pkg::STATUS_W-1:0]  out_status;
  ale_pkg::word_t                out_word;
  logic [ale_pkg::FOUND_W-1:0]   out_found;
  logic [CW-1:0]                 out_count;
  logic [ale_pkg::CURSOR_W-1:0]  out_cursor;

  // store port
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [ale_pkg::WORD_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [ale_pkg::WORD_W-1:0] mem_rdata;

  // decode of the incoming command
  ale_pkg::op_t  cmd_op;
  logic          accept;
  logic          full;
  logic          empty;
  logic [CW-1:0] cnt_m1;
  logic          pos_lt_cnt;
  logic          pos_le_cnt;
  logic          pos_lt_cnt_m1;
  logic          cur_in;
  logic          last_idx;
  logic          out_free;

  assign cmd_op        = ale_pkg::op_t'(cmd.opcode);
  assign accept        = cmd.valid && cmd.ready;
  assign full          = (cnt == CW'(ale_pkg::CAPACITY));
  assign empty         = (cnt == '0);
  assign cnt_m1        = cnt - 1'b1;
  assign pos_lt_cnt    = (cmd.position < cnt);
  assign pos_le_cnt    = (cmd.position <= cnt);
  assign pos_lt_cnt_m1 = !empty && (cmd.position < cnt_m1);
  assign cur_in        = (CW'(cur) < cnt);
  assign last_idx      = (CW'(idx) == cnt_m1);
  assign out_free      = !out_valid || rsp.ready;

  assign cmd.ready = (state == S_IDLE);

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.word_out   = out_word;
  assign rsp.found_at   = out_found;
  assign rsp.count_now  = out_count;
  assign rsp.cursor_now = out_cursor;

  ale_ram #(
    .WIDTH (ale_pkg::WORD_W),
    .DEPTH (ale_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Store addressing. Shifts are pipelined: the word read last cycle is
  // written one place over while the next one is read, so a read never hits
  // an entry already moved.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[AW-1:0];
    mem_wdata = cmd.word_in;
    mem_raddr = idx;
    unique case (state)
      S_IDLE: begin
        unique case (cmd_op)
          ale_pkg::OP_APPEND: begin
            mem_we    = accept && !full;
            mem_waddr = cnt[AW-1:0];
          end
          ale_pkg::OP_INSERT_AT: begin
            // insert at the tail needs no shift
            mem_we    = accept && !full && (cmd.position == cnt);
            mem_waddr = cmd.position[AW-1:0];
            mem_raddr = cnt_m1[AW-1:0];
          end
          ale_pkg::OP_REMOVE_AT: begin
            mem_raddr = cmd.position[AW-1:0] + 1'b1;
          end
          ale_pkg::OP_GET: begin
            mem_raddr = cmd.position[AW-1:0];
          end
          ale_pkg::OP_UPDATE: begin
            mem_we    = accept && pos_lt_cnt;
            mem_waddr = cmd.position[AW-1:0];
          end
          ale_pkg::OP_SEARCH: begin
            mem_raddr = '0;
          end
          ale_pkg::OP_READ: begin
            mem_raddr = cur;
          end
          ale_pkg::OP_WRITE: begin
            mem_we    = accept && !empty && cur_in;
            mem_waddr = cur;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_SHIFT_R: begin
        mem_we    = 1'b1;
        mem_waddr = idx + 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = idx - 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = word_r;
      end
      S_SHIFT_L: begin
        mem_we    = 1'b1;
        mem_waddr = idx - 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = idx + 1'b1;
      end
      S_SEARCH: begin
        mem_raddr = idx + 1'b1;
      end
      S_WAIT_RD, S_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Status of the command on offer, and the next step of the walk
  always_comb begin
    res_status_next = ale_pkg::ST_OK;
    state_next      = state;
    unique case (state)
      S_IDLE: begin
        state_next = accept ? S_DONE : S_IDLE;
        unique case (cmd_op)
          ale_pkg::OP_APPEND: begin
            if (full) begin
              res_status_next = ale_pkg::ST_FULL;
            end
          end
          ale_pkg::OP_INSERT_AT: begin
            priority if (!pos_le_cnt) begin
              res_status_next = ale_pkg::ST_RANGE;
            end else if (full) begin
              res_status_next = ale_pkg::ST_FULL;
            end else begin
              if (accept && pos_lt_cnt) begin
                state_next = S_SHIFT_R;
              end
            end
          end
          ale_pkg::OP_REMOVE_AT: begin
            if (!pos_lt_cnt) begin
              res_status_next = ale_pkg::ST_RANGE;
            end else if (accept && pos_lt_cnt_m1) begin
              state_next = S_SHIFT_L;
            end
          end
          ale_pkg::OP_REMOVE_LAST: begin
            if (empty) begin
              res_status_next = ale_pkg::ST_EMPTY;
            end
          end
          ale_pkg::OP_GET: begin
            if (!pos_lt_cnt) begin
              res_status_next = ale_pkg::ST_RANGE;
            end else if (accept) begin
              state_next = S_WAIT_RD;
            end
          end
          ale_pkg::OP_UPDATE: begin
            if (!pos_lt_cnt) begin
              res_status_next = ale_pkg::ST_RANGE;
            end
          end
          ale_pkg::OP_SEARCH: begin
            if (empty) begin
              res_status_next = ale_pkg::ST_NOTFOUND;
            end else if (accept) begin
              state_next = S_SEARCH;
            end
          end
          ale_pkg::OP_READ, ale_pkg::OP_WRITE: begin
            priority if (empty) begin
              res_status_next = ale_pkg::ST_EMPTY;
            end else if (!cur_in) begin
              res_status_next = ale_pkg::ST_RANGE;
            end else begin
              if (accept && cmd_op == ale_pkg::OP_READ) begin
                state_next = S_WAIT_RD;
              end
            end
          end
          default: begin
            res_status_next = ale_pkg::ST_OK;
          end
        endcase
      end
      S_SHIFT_R: begin
        // the word just moved came from the insert position: drop in the new word
        if (idx == pos_r[AW-1:0]) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        state_next = S_DONE;
      end
      S_SHIFT_L: begin
        if (last_idx) begin
          state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        if ((mem_rdata == word_r) || last_idx) begin
          state_next = S_DONE;
        end
      end
      S_WAIT_RD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the response register is free
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // raise the response when a finished item moves in; drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= res_status_next;
            res_data   <= '0;
            res_found  <= '0;
            word_r     <= cmd.word_in;
            pos_r      <= cmd.position;
            unique case (cmd_op)
              ale_pkg::OP_APPEND: begin
                if (!full) begin
                  cur <= cnt[AW-1:0];
                  cnt <= cnt + 1'b1;
                end
              end
              ale_pkg::OP_INSERT_AT: begin
                if (pos_le_cnt && !full) begin
                  if (pos_lt_cnt) begin
                    idx <= cnt_m1[AW-1:0];
                  end else begin
                    cnt <= cnt + 1'b1;
                  end
                end
              end
              ale_pkg::OP_REMOVE_AT: begin
                if (pos_lt_cnt) begin
                  if (pos_lt_cnt_m1) begin
                    idx <= cmd.position[AW-1:0] + 1'b1;
                  end else begin
                    cnt <= cnt_m1;
                  end
                end
              end
              ale_pkg::OP_REMOVE_LAST: begin
                if (!empty) begin
                  cnt <= cnt_m1;
                end
              end
              ale_pkg::OP_SEARCH: begin
                idx <= '0;
              end
              ale_pkg::OP_CLEAR: begin
                cnt <= '0;
                cur <= '0;
              end
              ale_pkg::OP_CUR_START: begin
                cur <= '0;
              end
              ale_pkg::OP_CUR_END: begin
                cur <= empty ? '0 : cnt_m1[AW-1:0];
              end
              ale_pkg::OP_CUR_NEXT: begin
                if ((CW'(cur) + 1'b1) < cnt) begin
                  cur <= cur + 1'b1;
                end
              end
              ale_pkg::OP_CUR_BACK: begin
                if (cur != '0) begin
                  cur <= cur - 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SHIFT_R: begin
          if (idx != pos_r[AW-1:0]) begin
            idx <= idx - 1'b1;
          end
        end

        S_PUT: begin
          cnt <= cnt + 1'b1;
        end

        S_SHIFT_L: begin
          if (last_idx) begin
            cnt <= cnt_m1;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_SEARCH: begin
          priority if (mem_rdata == word_r) begin
            res_found <= idx;
          end else if (last_idx) begin
            res_status <= ale_pkg::ST_NOTFOUND;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_WAIT_RD: begin
          res_data <= mem_rdata;
        end

        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_word   <= (res_status != ale_pkg::ST_OK) ? '1 : res_data;
            out_found  <= res_found;
            out_count  <= cnt;
            out_cursor <= cur;
          end
        end

        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ale_pkg::CAPACITY))
    else $error("word count beyond capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_waddr) <= cnt))
    else $error("store write beyond the end of the list");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished item not presented");
`endif

endmodule

`default_nettype wire

// ===== verif/array_list_engine_unit_test.sv =====
`timescale 1ns / 1ps

module array_list_engine_unit_test;

  // Opcodes outside the defined set: the block must answer ok and change nothing
  localparam logic [ale_pkg::OP_W-1:0] OP_UNUSED_A = 4'd14;
  localparam logic [ale_pkg::OP_W-1:0] OP_UNUSED_B = 4'd15;

  localparam ale_pkg::word_t WORD_MAX  = 32'sh7FFF_FFFF;
  localparam ale_pkg::word_t WORD_MIN  = 32'sh8000_0000;
  localparam ale_pkg::word_t WORD_ONES = -32'sd1;

  // Allow well over the longest command before the final verdict
  localparam int DRAIN_CYCLES = 1100;
  localparam int TIMEOUT_NS   = 200_000_000;

  typedef struct {
    ale_pkg::status_t                status;
    ale_pkg::word_t                  word_out;
    logic [ale_pkg::FOUND_W-1:0]     found_at;
    logic [ale_pkg::CNT_W-1:0]       count_now;
    logic [ale_pkg::CURSOR_W-1:0]    cursor_now;
  } list_result_t;

  // Mirror of the list: holds its own store, length and cursor, queues the
  // response each accepted command should produce and checks responses in order.
  class list_scoreboard;
    ale_pkg::word_t store_words [ale_pkg::CAPACITY];
    int unsigned    list_len;
    int unsigned    cursor_pos;
    list_result_t   pending_results [$];
    int unsigned    error_count;

    function new();
      list_len    = 0;
      cursor_pos  = 0;
      error_count = 0;
    endfunction

    function void note_command(logic [ale_pkg::OP_W-1:0] opc,
                               logic [ale_pkg::POS_W-1:0] pos, ale_pkg::word_t w);
      list_result_t r;
      int unsigned  p;
      bit           hit;
      r.status   = ale_pkg::ST_OK;
      r.word_out = '0;
      r.found_at = '0;
      p          = pos;
      hit        = 1'b0;
      case (opc)
        ale_pkg::OP_APPEND: begin
          if (list_len >= ale_pkg::CAPACITY) begin
            r.status = ale_pkg::ST_FULL;
          end else begin
            store_words[list_len] = w;
            cursor_pos = list_len;
            list_len++;
          end
        end
        ale_pkg::OP_INSERT_AT: begin
          if (p > list_len) begin
            r.status = ale_pkg::ST_RANGE;
          end else if (list_len >= ale_pkg::CAPACITY) begin
            r.status = ale_pkg::ST_FULL;
          end else begin
            for (int unsigned i = list_len; i > p; i--)
              store_words[i] = store_words[i - 1];
            store_words[p] = w;
            list_len++;
          end
        end
        ale_pkg::OP_REMOVE_AT: begin
          if (p >= list_len) begin
            r.status = ale_pkg::ST_RANGE;
          end else begin
            for (int unsigned i = p; i + 1 < list_len; i++)
              store_words[i] = store_words[i + 1];
            list_len--;
          end
        end
        ale_pkg::OP_REMOVE_LAST: begin
          if (list_len == 0) r.status = ale_pkg::ST_EMPTY;
          else list_len--;
        end
        ale_pkg::OP_GET: begin
          if (p >= list_len) r.status = ale_pkg::ST_RANGE;
          else r.word_out = store_words[p];
        end
        ale_pkg::OP_UPDATE: begin
          if (p >= list_len) r.status = ale_pkg::ST_RANGE;
          else store_words[p] = w;
        end
        ale_pkg::OP_SEARCH: begin
          for (int unsigned i = 0; i < list_len && !hit; i++) begin
            if (store_words[i] == w) begin
              hit = 1'b1;
              r.found_at = ale_pkg::FOUND_W'(i);
            end
          end
          if (!hit) r.status = ale_pkg::ST_NOTFOUND;
        end
        ale_pkg::OP_CLEAR: begin
          list_len   = 0;
          cursor_pos = 0;
        end
        ale_pkg::OP_CUR_START: cursor_pos = 0;
        ale_pkg::OP_CUR_END: cursor_pos = (list_len == 0) ? 0 : list_len - 1;
        ale_pkg::OP_CUR_NEXT: begin
          if (list_len != 0 && cursor_pos + 1 < list_len) cursor_pos++;
        end
        ale_pkg::OP_CUR_BACK: begin
          if (cursor_pos > 0) cursor_pos--;
        end
        ale_pkg::OP_READ: begin
          if (list_len == 0) r.status = ale_pkg::ST_EMPTY;
          else if (cursor_pos >= list_len) r.status = ale_pkg::ST_RANGE;
          else r.word_out = store_words[cursor_pos];
        end
        ale_pkg::OP_WRITE: begin
          if (list_len == 0) r.status = ale_pkg::ST_EMPTY;
          else if (cursor_pos >= list_len) r.status = ale_pkg::ST_RANGE;
          else store_words[cursor_pos] = w;
        end
        default: ;
      endcase
      if (r.status != ale_pkg::ST_OK) r.word_out = WORD_ONES;
      r.count_now  = ale_pkg::CNT_W'(list_len);
      r.cursor_now = ale_pkg::CURSOR_W'(cursor_pos);
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [ale_pkg::STATUS_W-1:0] st, ale_pkg::word_t wo,
                                 logic [ale_pkg::FOUND_W-1:0] fa,
                                 logic [ale_pkg::CNT_W-1:0] cn,
                                 logic [ale_pkg::CURSOR_W-1:0] cu);
      list_result_t r;
      if (pending_results.size() == 0) begin
        $error("response item with no command outstanding");
        error_count++;
        return;
      end
      r = pending_results.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        error_count++;
      end
      if (wo !== r.word_out) begin
        $error("word_out: expected %0d, actual %0d", r.word_out, wo);
        error_count++;
      end
      if (fa !== r.found_at) begin
        $error("found_at: expected %0d, actual %0d", r.found_at, fa);
        error_count++;
      end
      if (cn !== r.count_now) begin
        $error("count_now: expected %0d, actual %0d", r.count_now, cn);
        error_count++;
      end
      if (cu !== r.cursor_now) begin
        $error("cursor_now: expected %0d, actual %0d", r.cursor_now, cu);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idling_on;
  int unsigned stall_left = 0;

  list_scoreboard sb;

  ale_cmd_if cmd_ch ();
  ale_rsp_if rsp_ch ();

  array_list_engine_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side back-pressure: while idling is on, drop ready now and then
  // for a short burst; otherwise hold it high.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 15);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Check every response item taken at an edge against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.word_out, rsp_ch.found_at,
                        rsp_ch.count_now, rsp_ch.cursor_now);
  end

  // Offer one command item and hold it until the block takes it. The mirror
  // is advanced at the accepting edge, so the next pick sees the list as the
  // block holds it. Afterwards insert an optional gap with valid low.
  task automatic send_command(input logic [ale_pkg::OP_W-1:0] opc,
                              input logic [ale_pkg::POS_W-1:0] pos,
                              input ale_pkg::word_t w);
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= opc;
    cmd_ch.position <= pos;
    cmd_ch.word_in  <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(opc, pos, w);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Draw one random command. The list length is steered towards target_len so
  // that most of the run works on short lists and shifts and searches stay
  // cheap. Words are drawn partly from a small pool and partly from the list
  // itself, so that searches hit and duplicates test the first-match rule.
  function automatic void pick_command(input int unsigned target_len,
                                       output logic [ale_pkg::OP_W-1:0] opc,
                                       output logic [ale_pkg::POS_W-1:0] pos,
                                       output ale_pkg::word_t w);
    int unsigned roll;
    int unsigned len;
    len  = sb.list_len;
    roll = $urandom_range(0, 99);
    if (len < target_len && roll < 30) begin
      opc = (roll < 20) ? ale_pkg::OP_APPEND : ale_pkg::OP_INSERT_AT;
    end else if (len > target_len && roll < 20) begin
      opc = (roll < 12) ? ale_pkg::OP_REMOVE_AT : ale_pkg::OP_REMOVE_LAST;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 12) opc = ale_pkg::OP_APPEND;
      else if (roll < 22) opc = ale_pkg::OP_INSERT_AT;
      else if (roll < 31) opc = ale_pkg::OP_REMOVE_AT;
      else if (roll < 36) opc = ale_pkg::OP_REMOVE_LAST;
      else if (roll < 46) opc = ale_pkg::OP_GET;
      else if (roll < 53) opc = ale_pkg::OP_UPDATE;
      else if (roll < 64) opc = ale_pkg::OP_SEARCH;
      else if (roll < 66) opc = ale_pkg::OP_CLEAR;
      else if (roll < 69) opc = ale_pkg::OP_CUR_START;
      else if (roll < 73) opc = ale_pkg::OP_CUR_END;
      else if (roll < 78) opc = ale_pkg::OP_CUR_NEXT;
      else if (roll < 83) opc = ale_pkg::OP_CUR_BACK;
      else if (roll < 90) opc = ale_pkg::OP_READ;
      else if (roll < 96) opc = ale_pkg::OP_WRITE;
      else if (roll < 98) opc = OP_UNUSED_A;
      else opc = OP_UNUSED_B;
    end

    // Mostly in range or at the boundary; now and then anything the field holds
    roll = $urandom_range(0, 99);
    if (roll < 75) pos = ale_pkg::POS_W'($urandom_range(0, len));
    else if (roll < 88) pos = ale_pkg::POS_W'(len + $urandom_range(0, 1));
    else pos = ale_pkg::POS_W'($urandom_range(0, (1 << ale_pkg::POS_W) - 1));

    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      w = $urandom;
    end else if (roll < 65) begin
      case ($urandom_range(0, 7))
        0: w = '0;
        1: w = WORD_ONES;
        2: w = WORD_MAX;
        3: w = WORD_MIN;
        default: w = ale_pkg::word_t'($urandom_range(1, 4));
      endcase
    end else if (len != 0) begin
      w = sb.store_words[$urandom_range(0, len - 1)];
    end else begin
      w = $urandom;
    end
  endfunction

  initial begin
    int unsigned                 target_len;
    logic [ale_pkg::OP_W-1:0]    opc;
    logic [ale_pkg::POS_W-1:0]   pos;
    ale_pkg::word_t              w;

    sb              = new();
    cmd_ch.valid    = 1'b0;
    cmd_ch.opcode   = '0;
    cmd_ch.position = '0;
    cmd_ch.word_in  = '0;
    idling_on       = 1'b1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every command that needs a word must refuse
    send_command(ale_pkg::OP_REMOVE_LAST, '0, '0);
    send_command(ale_pkg::OP_READ, '0, '0);
    send_command(ale_pkg::OP_WRITE, '0, WORD_MAX);
    send_command(ale_pkg::OP_CUR_END, '0, '0);       // repaired to 0 on an empty list
    send_command(ale_pkg::OP_CUR_NEXT, '0, '0);      // stays on an empty list
    send_command(ale_pkg::OP_CUR_BACK, '0, '0);      // stops at 0
    send_command(ale_pkg::OP_GET, '0, '0);
    send_command(ale_pkg::OP_INSERT_AT, 11'd1, '0);  // past the end
    send_command(ale_pkg::OP_SEARCH, '0, '0);        // nothing to find

    // Build [max, 0, min, -1, -1] from both ends and the middle
    send_command(ale_pkg::OP_INSERT_AT, '0, WORD_MAX);
    send_command(ale_pkg::OP_APPEND, '0, WORD_MIN);
    send_command(ale_pkg::OP_APPEND, '0, WORD_ONES);
    send_command(ale_pkg::OP_INSERT_AT, 11'd1, '0);
    send_command(ale_pkg::OP_APPEND, '0, WORD_ONES);
    send_command(ale_pkg::OP_SEARCH, '0, WORD_ONES); // duplicate: first match wins
    send_command(ale_pkg::OP_GET, 11'd2047, '0);
    send_command(ale_pkg::OP_UPDATE, '0, ale_pkg::word_t'(1));

    // Removal leaves the cursor at the old end, beyond the new length
    send_command(ale_pkg::OP_REMOVE_AT, '0, '0);
    send_command(ale_pkg::OP_READ, '0, '0);
    send_command(ale_pkg::OP_WRITE, '0, WORD_MIN);
    send_command(ale_pkg::OP_CUR_NEXT, '0, '0);
    send_command(ale_pkg::OP_CUR_START, '0, '0);
    send_command(OP_UNUSED_A, 11'd2047, WORD_ONES);
    send_command(OP_UNUSED_B, 11'd2047, WORD_ONES);
    send_command(ale_pkg::OP_CLEAR, '0, '0);

    // Random traffic on short lists; idling alternates, last blocks run flat out
    for (int blk = 0; blk < 10; blk++) begin
      idling_on  <= (blk < 8) && (blk % 3 != 2);
      target_len = $urandom_range(0, 40);
      repeat (55) begin
        pick_command(target_len, opc, pos, w);
        send_command(opc, pos, w);
      end
    end

    cmd_ch.valid <= 1'b0;
    idling_on    <= 1'b0;

    // Drain, then hold on long enough to catch any stray response
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
